>>> src/assert_macros.svh
// assertion macros used by the port-level checker (mfd_checker.sv)
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every edge outside reset
`define MFD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// checked at every edge, reset included
`define MFD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

>>> src/mfd_pkg.sv
// constants, types and decode tables of the meter frame decoder
// no dependencies
package mfd_pkg;

  localparam int unsigned CountBitsDef = 16;
  localparam int unsigned RdW          = 41;
  localparam int unsigned WinLen       = 13;
  localparam int unsigned DigW         = 17;
  localparam int unsigned PowW         = 24;
  localparam int unsigned NumDigits    = 5;

  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChCr   = 8'h0d;
  localparam logic [7:0] ChLf   = 8'h0a;

  localparam logic [7:0] FcVolt  = 8'h3b;
  localparam logic [7:0] FcCurA  = 8'h30;
  localparam logic [7:0] FcCurMa = 8'h3d;
  localparam logic [7:0] FcCurUa = 8'h3f;
  localparam logic [7:0] FcRes   = 8'h33;
  localparam logic [7:0] FcDiode = 8'h31;
  localparam logic [7:0] FcFreq  = 8'h32;
  localparam logic [7:0] FcCap   = 8'h36;
  localparam logic [7:0] FcCond  = 8'h35;

  localparam logic [2:0] FnVolt  = 3'd0;
  localparam logic [2:0] FnCur   = 3'd1;
  localparam logic [2:0] FnRes   = 3'd2;
  localparam logic [2:0] FnDiode = 3'd3;
  localparam logic [2:0] FnFreq  = 3'd4;
  localparam logic [2:0] FnCap   = 3'd5;
  localparam logic [2:0] FnCond  = 3'd6;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StFrame = 2'd1;
  localparam logic [1:0] StCode  = 2'd2;

  localparam logic [1:0] CplNone = 2'd0;
  localparam logic [1:0] CplAc   = 2'd1;
  localparam logic [1:0] CplDc   = 2'd2;

  localparam logic [1:0] LdNormal = 2'd0;
  localparam logic [1:0] LdOver   = 2'd1;
  localparam logic [1:0] LdUnder  = 2'd2;

  localparam logic [1:0] PkMax = 2'd1;
  localparam logic [1:0] PkMin = 2'd2;

  localparam logic [1:0] SmFreq = 2'd1;
  localparam logic [1:0] SmDuty = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_DIGIT, S_SCALE, S_UPDATE, S_DIV_INIT, S_DIVIDE, S_OUTPUT
  } state_e;

  typedef struct packed {
    logic       ok;
    logic [2:0] func;
    logic [2:0] shift;
  } dec_t;

  function automatic dec_t decode_func(logic [7:0] fc, logic [7:0] rc);
    dec_t       d;
    logic       rv;
    logic [3:0] r;
    d  = '0;
    rv = (rc >= ChZero) && (rc <= ChNine);
    r  = rc[3:0];
    unique case (fc)
      FcVolt: begin
        d.func = FnVolt;
        if (rv && r <= 4'd3) begin
          d.ok = 1'b1;
          d.shift = r[2:0] + 3'd1;
        end else if (rv && r == 4'd4) begin
          d.ok = 1'b1;
        end
      end
      FcCurA: begin
        d.func = FnCur;
        d.ok = rv && r == 4'd0;
        d.shift = 3'd5;
      end
      FcCurMa: begin
        d.func = FnCur;
        d.ok = rv && r <= 4'd1;
        d.shift = r[2:0];
      end
      FcCurUa: begin
        d.func = FnCur;
        d.ok = rv && r <= 4'd1;
        d.shift = r[2:0] + 3'd2;
      end
      FcRes: begin
        d.func = FnRes;
        d.ok = rv && r <= 4'd6;
        d.shift = r[2:0];
      end
      FcDiode: begin
        d.func = FnDiode;
        d.ok = 1'b1;
      end
      FcFreq: begin
        d.func = FnFreq;
        if (rv && r <= 4'd1) begin
          d.ok = 1'b1;
          d.shift = r[2:0];
        end else if (rv && r >= 4'd3 && r <= 4'd7) begin
          d.ok = 1'b1;
          d.shift = r[2:0] - 3'd1;
        end
      end
      FcCap: begin
        d.func = FnCap;
        d.ok = rv && r <= 4'd7;
        d.shift = r[2:0];
      end
      FcCond: begin
        d.func = FnCond;
        d.ok = 1'b1;
      end
      default: d = '0;
    endcase
    return d;
  endfunction

  function automatic logic signed [4:0] lsb_exp(logic [2:0] func);
    logic signed [4:0] e;
    unique case (func)
      FnVolt:  e = -5'sd5;
      FnCur:   e = -5'sd8;
      FnRes:   e = -5'sd2;
      FnFreq:  e = -5'sd2;
      FnCap:   e = -5'sd12;
      default: e = 5'sd0;
    endcase
    return e;
  endfunction

  function automatic logic [PowW-1:0] pow10(logic [2:0] shift);
    logic [PowW-1:0] p;
    unique case (shift)
      3'd0:    p = 24'd1;
      3'd1:    p = 24'd10;
      3'd2:    p = 24'd100;
      3'd3:    p = 24'd1000;
      3'd4:    p = 24'd10000;
      3'd5:    p = 24'd100000;
      3'd6:    p = 24'd1000000;
      default: p = 24'd10000000;
    endcase
    return p;
  endfunction

endpackage

>>> src/meter_frame_decoder.sv
// meter frame decoder top level: byte window, frame decode, running statistics
// depends on mfd_pkg
//
// Usage: bytes of the meter's serial stream enter on the rx channel
// (rx_valid_i / rx_ready_o / rx_byte_i). The last 13 bytes are kept; a
// line-feed byte closes a 14-byte frame, which is checked and decoded into
// one result on the out channel (out_valid_o / out_ready_i and the fields).
// Other bytes give no result and do not hold the channel.
// A line feed takes CHECK, five digit steps (one ASCII digit a cycle),
// SCALE, UPDATE, DIV_INIT, then 41 + COUNT_BITS steps of the bit-serial
// mean divider (one quotient bit a cycle), then OUTPUT; a frame that
// fails its checks goes from CHECK straight to OUTPUT.
// rx_ready_o is high only while no frame is in work.
// Reset clears the byte window, the held modes and the running statistics.
// A stalled receiver holds the result in the output register; bytes
// are still accepted, and a further frame waits in OUTPUT until the
// register is free.
module meter_frame_decoder
  import mfd_pkg::*;
#(
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rx_valid_i,
  output logic                  rx_ready_o,
  input  logic [7:0]            rx_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output logic [2:0]            function_code_o,
  output logic signed [RdW-1:0] reading_o,
  output logic signed [4:0]     lsb_exponent_o,
  output logic signed [RdW-1:0] max_reading_o,
  output logic signed [RdW-1:0] min_reading_o,
  output logic signed [RdW-1:0] mean_reading_o,
  output logic [1:0]            coupling_o,
  output logic [3:0]            flag_bits_o,
  output logic [1:0]            load_state_o,
  output logic [1:0]            peak_state_o,
  output logic [1:0]            freq_submode_o
);

  localparam int unsigned SumW    = RdW + COUNT_BITS;
  localparam int unsigned DivCntW = $clog2(SumW + 1);
  localparam int unsigned DigCntW = $clog2(NumDigits + 1);

  state_e state_q, state_d;

  logic [7:0] win_q [WinLen];
  logic [7:0] frame_q [WinLen];
  logic [7:0] dig_sr_q [NumDigits];

  logic [DigCntW-1:0] dig_cnt_q, dig_cnt_d;
  logic               stop_q, stop_d;
  logic [DigW-1:0]    digits_q, digits_d;
  dec_t               dec_q, dec_d;
  logic [1:0]         status_q, status_d;
  logic signed [RdW-1:0] reading_q, reading_d;

  logic [2:0]            func_q, func_d;
  logic [1:0]            cpl_q, cpl_d, peak_q, peak_d, sub_q, sub_d;
  logic signed [RdW-1:0] max_q, max_d, min_q, min_d;
  logic [SumW-1:0]       sum_q, sum_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;

  logic [SumW-1:0]       div_q, div_d;
  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic                  neg_q, neg_d;
  logic [DivCntW-1:0]    div_cnt_q, div_cnt_d;

  logic                  ovalid_q, ovalid_d, load_out;

  logic                  rx_acc;
  logic [7:0]            cur_dig;
  logic                  is_dig;
  logic [RdW-1:0]        mag;
  logic signed [RdW-1:0] base_max, base_min;
  logic [SumW-1:0]       base_sum;
  logic [COUNT_BITS-1:0] base_cnt;
  logic                  fn_change;
  logic [COUNT_BITS:0]   rem_w;
  logic                  q_bit;
  logic [RdW-1:0]        quot;
  logic signed [RdW-1:0] mean_val;

  assign rx_ready_o = (state_q == S_IDLE);
  assign rx_acc     = rx_valid_i && rx_ready_o;
  assign cur_dig    = dig_sr_q[0];
  assign is_dig     = (cur_dig >= ChZero) && (cur_dig <= ChNine);
  assign mag        = RdW'(digits_q) * RdW'(pow10(dec_q.shift));
  assign fn_change  = (dec_q.func != func_q);
  assign base_max   = fn_change ? '0 : max_q;
  assign base_min   = fn_change ? '0 : min_q;
  assign base_sum   = fn_change ? '0 : sum_q;
  assign base_cnt   = fn_change ? '0 : cnt_q;
  assign rem_w      = {rem_q, div_q[SumW-1]};
  assign q_bit      = (rem_w >= {1'b0, cnt_q});
  assign quot       = div_q[RdW-1:0];
  assign mean_val   = (cnt_q == '0) ? '0 : (neg_q ? -$signed(quot) : $signed(quot));
  assign load_out   = (state_q == S_OUTPUT) && (!ovalid_q || out_ready_i);

  always_comb begin
    state_d   = state_q;
    dig_cnt_d = dig_cnt_q;
    stop_d    = stop_q;
    digits_d  = digits_q;
    dec_d     = dec_q;
    status_d  = status_q;
    reading_d = reading_q;
    func_d    = func_q;
    cpl_d     = cpl_q;
    peak_d    = peak_q;
    sub_d     = sub_q;
    max_d     = max_q;
    min_d     = min_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    div_d     = div_q;
    rem_d     = rem_q;
    neg_d     = neg_q;
    div_cnt_d = div_cnt_q;
    ovalid_d  = ovalid_q && !out_ready_i;
    if (load_out) ovalid_d = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (rx_acc && rx_byte_i == ChLf) state_d = S_CHECK;
      end
      S_CHECK: begin
        dec_d     = decode_func(frame_q[6], frame_q[0]);
        dig_cnt_d = '0;
        stop_d    = 1'b0;
        digits_d  = '0;
        if ((frame_q[0] & 8'h30) != 8'h30 || frame_q[12] != ChCr) begin
          status_d = StFrame;
          state_d  = S_OUTPUT;
        end else if (!decode_func(frame_q[6], frame_q[0]).ok) begin
          status_d = StCode;
          state_d  = S_OUTPUT;
        end else begin
          status_d = StOk;
          state_d  = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (!stop_q && is_dig) begin
          digits_d = (digits_q << 3) + (digits_q << 1) + DigW'(cur_dig[3:0]);
        end else begin
          stop_d = 1'b1;
        end
        dig_cnt_d = dig_cnt_q + 1'b1;
        if (dig_cnt_q == DigCntW'(NumDigits - 1)) state_d = S_SCALE;
      end
      S_SCALE: begin
        reading_d = frame_q[7][2] ? -$signed(mag) : $signed(mag);
        state_d   = S_UPDATE;
      end
      S_UPDATE: begin
        if (frame_q[10][3]) cpl_d = CplDc;
        else if (frame_q[10][2]) cpl_d = CplAc;
        if (frame_q[9][2]) peak_d = PkMax;
        else if (frame_q[9][1]) peak_d = PkMin;
        if (frame_q[7][3]) sub_d = SmDuty;
        else if (frame_q[10][0]) sub_d = SmFreq;
        func_d = dec_q.func;
        max_d  = (reading_q > base_max) ? reading_q : base_max;
        min_d  = (reading_q < base_min) ? reading_q : base_min;
        sum_d  = base_sum;
        cnt_d  = base_cnt;
        if (base_cnt != '1) begin
          sum_d = base_sum + {{COUNT_BITS{reading_q[RdW-1]}}, reading_q};
          cnt_d = base_cnt + 1'b1;
        end
        state_d = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        neg_d     = sum_q[SumW-1];
        div_d     = sum_q[SumW-1] ? -sum_q : sum_q;
        rem_d     = '0;
        div_cnt_d = '0;
        state_d   = S_DIVIDE;
      end
      S_DIVIDE: begin
        // restoring division, quotient bits shift into the dividend register
        rem_d     = q_bit ? COUNT_BITS'(rem_w - {1'b0, cnt_q}) : rem_w[COUNT_BITS-1:0];
        div_d     = {div_q[SumW-2:0], q_bit};
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == DivCntW'(SumW - 1)) state_d = S_OUTPUT;
      end
      S_OUTPUT: begin
        if (load_out) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ovalid_q  <= 1'b0;
      func_q    <= FnVolt;
      cpl_q     <= CplNone;
      peak_q    <= '0;
      sub_q     <= '0;
      max_q     <= '0;
      min_q     <= '0;
      sum_q     <= '0;
      cnt_q     <= '0;
      dig_cnt_q <= '0;
      div_cnt_q <= '0;
      for (int i = 0; i < WinLen; i++) win_q[i] <= '0;
    end else begin
      state_q   <= state_d;
      ovalid_q  <= ovalid_d;
      func_q    <= func_d;
      cpl_q     <= cpl_d;
      peak_q    <= peak_d;
      sub_q     <= sub_d;
      max_q     <= max_d;
      min_q     <= min_d;
      sum_q     <= sum_d;
      cnt_q     <= cnt_d;
      dig_cnt_q <= dig_cnt_d;
      div_cnt_q <= div_cnt_d;
      if (rx_acc) begin
        for (int i = 0; i < WinLen - 1; i++) win_q[i] <= win_q[i + 1];
        win_q[WinLen-1] <= rx_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    stop_q    <= stop_d;
    digits_q  <= digits_d;
    dec_q     <= dec_d;
    status_q  <= status_d;
    reading_q <= reading_d;
    div_q     <= div_d;
    rem_q     <= rem_d;
    neg_q     <= neg_d;
    if (rx_acc && rx_byte_i == ChLf) begin
      for (int i = 0; i < WinLen; i++) frame_q[i] <= win_q[i];
      for (int i = 0; i < NumDigits; i++) dig_sr_q[i] <= win_q[i + 1];
    end else if (state_q == S_DIGIT) begin
      for (int i = 0; i < NumDigits - 1; i++) dig_sr_q[i] <= dig_sr_q[i + 1];
      dig_sr_q[NumDigits-1] <= '0;
    end
  end

  // result register, error results carry zeros
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      status_o        <= status_q;
      if (status_q == StOk) begin
        function_code_o <= func_q;
        reading_o       <= reading_q;
        lsb_exponent_o  <= lsb_exp(func_q);
        max_reading_o   <= max_q;
        min_reading_o   <= min_q;
        mean_reading_o  <= mean_val;
        coupling_o      <= cpl_q;
        flag_bits_o     <= {frame_q[10][1], frame_q[11][1], frame_q[8][1], frame_q[7][1]};
        load_state_o    <= frame_q[7][0] ? LdOver : (frame_q[9][3] ? LdUnder : LdNormal);
        peak_state_o    <= peak_q;
        freq_submode_o  <= sub_q;
      end else begin
        function_code_o <= '0;
        reading_o       <= '0;
        lsb_exponent_o  <= '0;
        max_reading_o   <= '0;
        min_reading_o   <= '0;
        mean_reading_o  <= '0;
        coupling_o      <= '0;
        flag_bits_o     <= '0;
        load_state_o    <= '0;
        peak_state_o    <= '0;
        freq_submode_o  <= '0;
      end
    end
  end

  assign out_valid_o = ovalid_q;

endmodule

>>> src/mfd_checker.sv
// port-level checker of the meter frame decoder, bound to the top level
// depends on mfd_pkg and assert_macros.svh
`include "assert_macros.svh"

module mfd_checker
  import mfd_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [1:0]            status_o,
  input logic signed [RdW-1:0] reading_o,
  input logic signed [RdW-1:0] max_reading_o,
  input logic signed [RdW-1:0] min_reading_o,
  input logic signed [RdW-1:0] mean_reading_o
);

  logic nums_zero;
  logic in_range;

  assign nums_zero = (reading_o == '0) && (max_reading_o == '0) &&
                     (min_reading_o == '0) && (mean_reading_o == '0);
  assign in_range  = (min_reading_o <= reading_o) && (reading_o <= max_reading_o);

  `MFD_ASSERT_ALWAYS(a_no_valid_in_reset, clk_i, !rst_ni |=> !out_valid_o)

  `MFD_ASSERT(a_valid_holds, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o)

  `MFD_ASSERT(a_reading_holds, clk_i, rst_ni, out_valid_o && !out_ready_i |=> $stable(reading_o))

  // failed frames carry no numbers
  `MFD_ASSERT(a_error_zero, clk_i, rst_ni, out_valid_o && status_o != StOk |-> nums_zero)

  // the reading lies between running min and max
  `MFD_ASSERT(a_in_range, clk_i, rst_ni, out_valid_o && status_o == StOk |-> in_range)

endmodule

bind meter_frame_decoder mfd_checker u_mfd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .reading_o      (reading_o),
  .max_reading_o  (max_reading_o),
  .min_reading_o  (min_reading_o),
  .mean_reading_o (mean_reading_o)
);

>>> tb/meter_frame_checker.sv
// checker for the meter frame decoder: watches both channels, predicts each
// decoded frame and compares it field by field. depends on mfd_pkg
`timescale 1ns / 100ps

module meter_frame_checker
  import mfd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rx_valid_i,
  input  logic                  rx_ready_i,
  input  logic [7:0]            rx_byte_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [1:0]            status_i,
  input  logic [2:0]            function_code_i,
  input  logic signed [RdW-1:0] reading_i,
  input  logic signed [4:0]     lsb_exponent_i,
  input  logic signed [RdW-1:0] max_reading_i,
  input  logic signed [RdW-1:0] min_reading_i,
  input  logic signed [RdW-1:0] mean_reading_i,
  input  logic [1:0]            coupling_i,
  input  logic [3:0]            flag_bits_i,
  input  logic [1:0]            load_state_i,
  input  logic [1:0]            peak_state_i,
  input  logic [1:0]            freq_submode_i,
  output int                    fail_count_o,
  output int                    frames_pending_o
);

  typedef struct packed {
    logic [1:0]            status;
    logic [2:0]            func;
    logic signed [RdW-1:0] reading;
    logic signed [4:0]     expo;
    logic signed [RdW-1:0] max_rd;
    logic signed [RdW-1:0] min_rd;
    logic signed [RdW-1:0] mean_rd;
    logic [1:0]            coupling;
    logic [3:0]            flags;
    logic [1:0]            load;
    logic [1:0]            peak;
    logic [1:0]            submode;
  } meter_reading_t;

  meter_reading_t decoded_q[$];

  logic [7:0] window[WinLen];
  logic [2:0] cur_func;
  logic [1:0] cpl_hold, peak_hold, sub_hold;
  longint     run_max, run_min, run_sum;
  longint     run_count;
  int         fails;

  assign fail_count_o     = fails;
  assign frames_pending_o = decoded_q.size();

  // range digit -> decade shift, -1 when the code pair is unknown
  function automatic int decade_shift(logic [7:0] fc, logic [7:0] rc, output logic [2:0] fn);
    int r;
    r  = (rc >= ChZero && rc <= ChNine) ? int'(rc - ChZero) : -1;
    fn = FnVolt;
    case (fc)
      FcVolt: begin
        if (r >= 0 && r <= 3) return r + 1;
        return (r == 4) ? 0 : -1;
      end
      FcCurA: begin
        fn = FnCur;
        return (r == 0) ? 5 : -1;
      end
      FcCurMa: begin
        fn = FnCur;
        return (r == 0 || r == 1) ? r : -1;
      end
      FcCurUa: begin
        fn = FnCur;
        return (r == 0 || r == 1) ? r + 2 : -1;
      end
      FcRes: begin
        fn = FnRes;
        return (r >= 0 && r <= 6) ? r : -1;
      end
      FcDiode: begin
        fn = FnDiode;
        return 0;
      end
      FcFreq: begin
        fn = FnFreq;
        if (r == 0 || r == 1) return r;
        return (r >= 3 && r <= 7) ? r - 1 : -1;
      end
      FcCap: begin
        fn = FnCap;
        return (r >= 0 && r <= 7) ? r : -1;
      end
      FcCond: begin
        fn = FnCond;
        return 0;
      end
      default: return -1;
    endcase
  endfunction

  function automatic logic signed [4:0] unit_exponent(logic [2:0] fn);
    case (fn)
      FnVolt:        return -5'sd5;
      FnCur:         return -5'sd8;
      FnRes, FnFreq: return -5'sd2;
      FnCap:         return -5'sd12;
      default:       return 5'sd0;
    endcase
  endfunction

  task automatic decode_byte(input logic [7:0] rx);
    logic [7:0]     d[14];
    meter_reading_t e;
    logic [2:0]     fn;
    int             sh;
    bit             stop;
    longint         digits, rd;
    for (int i = 0; i < WinLen; i++) d[i] = window[i];
    d[13] = rx;
    for (int i = 0; i < WinLen - 1; i++) window[i] = window[i + 1];
    window[WinLen - 1] = rx;
    if (rx != ChLf) return;
    e = '0;
    if ((d[0] & 8'h30) != 8'h30 || d[12] != ChCr) begin
      e.status = StFrame;
      decoded_q.push_back(e);
      return;
    end
    sh = decade_shift(d[6], d[0], fn);
    if (sh < 0) begin
      e.status = StCode;
      decoded_q.push_back(e);
      return;
    end
    digits = 0;
    stop   = 0;
    for (int i = 1; i <= NumDigits; i++) begin
      if (stop || d[i] < ChZero || d[i] > ChNine) stop = 1;
      else digits = digits * 10 + longint'(d[i] - ChZero);
    end
    rd = digits;
    repeat (sh) rd = rd * 10;
    if (d[7][2]) rd = -rd;
    if (d[10][3]) cpl_hold = CplDc;
    else if (d[10][2]) cpl_hold = CplAc;
    if (d[9][2]) peak_hold = PkMax;
    else if (d[9][1]) peak_hold = PkMin;
    if (d[7][3]) sub_hold = SmDuty;
    else if (d[10][0]) sub_hold = SmFreq;
    if (fn != cur_func) begin
      cur_func  = fn;
      run_max   = 0;
      run_min   = 0;
      run_sum   = 0;
      run_count = 0;
    end
    if (rd > run_max) run_max = rd;
    if (rd < run_min) run_min = rd;
    // count saturates and freezes the mean
    if (run_count < (64'd1 << CountBitsDef) - 1) begin
      run_sum   += rd;
      run_count += 1;
    end
    e.status   = StOk;
    e.func     = fn;
    e.reading  = rd[RdW-1:0];
    e.expo     = unit_exponent(fn);
    e.max_rd   = run_max[RdW-1:0];
    e.min_rd   = run_min[RdW-1:0];
    e.mean_rd  = (run_count == 0) ? '0 : RdW'(run_sum / run_count);
    e.coupling = cpl_hold;
    e.flags    = {d[10][1], d[11][1], d[8][1], d[7][1]};
    e.load     = d[7][0] ? LdOver : (d[9][3] ? LdUnder : LdNormal);
    e.peak     = peak_hold;
    e.submode  = sub_hold;
    decoded_q.push_back(e);
  endtask

  task automatic report(input string field, input longint got, input longint want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
    fails++;
  endtask

  task automatic compare_result();
    meter_reading_t e;
    if (decoded_q.size() == 0) begin
      report("unexpected result", status_i, -1);
      return;
    end
    e = decoded_q.pop_front();
    if (status_i != e.status) report("status", status_i, e.status);
    if (function_code_i != e.func) report("function_code", function_code_i, e.func);
    if (reading_i != e.reading) report("reading", reading_i, e.reading);
    if (lsb_exponent_i != e.expo) report("lsb_exponent", lsb_exponent_i, e.expo);
    if (max_reading_i != e.max_rd) report("max_reading", max_reading_i, e.max_rd);
    if (min_reading_i != e.min_rd) report("min_reading", min_reading_i, e.min_rd);
    if (mean_reading_i != e.mean_rd) report("mean_reading", mean_reading_i, e.mean_rd);
    if (coupling_i != e.coupling) report("coupling", coupling_i, e.coupling);
    if (flag_bits_i != e.flags) report("flag_bits", flag_bits_i, e.flags);
    if (load_state_i != e.load) report("load_state", load_state_i, e.load);
    if (peak_state_i != e.peak) report("peak_state", peak_state_i, e.peak);
    if (freq_submode_i != e.submode) report("freq_submode", freq_submode_i, e.submode);
  endtask

  initial begin
    for (int i = 0; i < WinLen; i++) window[i] = '0;
    cur_func  = FnVolt;
    cpl_hold  = CplNone;
    peak_hold = '0;
    sub_hold  = '0;
    run_max   = 0;
    run_min   = 0;
    run_sum   = 0;
    run_count = 0;
    fails     = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) compare_result();
      if (rx_valid_i && rx_ready_i) decode_byte(rx_byte_i);
    end
  end

endmodule

>>> tb/meter_frame_decoder_test.sv
// testbench top for the meter frame decoder: clock, reset, byte stimulus,
// receiver stalls, watchdog and verdict. depends on mfd_pkg and meter_frame_checker
`timescale 1ns / 100ps

module meter_frame_decoder_test;
  import mfd_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int ByteTarget    = 1150;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  rx_valid = 1'b0;
  logic                  rx_ready;
  logic [7:0]            rx_byte = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            status;
  logic [2:0]            function_code;
  logic signed [RdW-1:0] reading, max_reading, min_reading, mean_reading;
  logic signed [4:0]     lsb_exponent;
  logic [1:0]            coupling, load_state, peak_state, freq_submode;
  logic [3:0]            flag_bits;
  int                    fail_count, frames_pending;
  int                    bytes_sent = 0;
  int                    quiet_cycles = 0;
  int                    stall_left = 0;
  bit                    calm = 0;

  always #6 clk_i = ~clk_i;

  meter_frame_decoder dut (
    .clk_i, .rst_ni,
    .rx_valid_i(rx_valid), .rx_ready_o(rx_ready), .rx_byte_i(rx_byte),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .status_o(status), .function_code_o(function_code), .reading_o(reading),
    .lsb_exponent_o(lsb_exponent), .max_reading_o(max_reading),
    .min_reading_o(min_reading), .mean_reading_o(mean_reading),
    .coupling_o(coupling), .flag_bits_o(flag_bits), .load_state_o(load_state),
    .peak_state_o(peak_state), .freq_submode_o(freq_submode)
  );

  meter_frame_checker u_checker (
    .clk_i, .rst_ni,
    .rx_valid_i(rx_valid), .rx_ready_i(rx_ready), .rx_byte_i(rx_byte),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .status_i(status), .function_code_i(function_code), .reading_i(reading),
    .lsb_exponent_i(lsb_exponent), .max_reading_i(max_reading),
    .min_reading_i(min_reading), .mean_reading_i(mean_reading),
    .coupling_i(coupling), .flag_bits_i(flag_bits), .load_state_i(load_state),
    .peak_state_i(peak_state), .freq_submode_i(freq_submode),
    .fail_count_o(fail_count), .frames_pending_o(frames_pending)
  );

  // receiver stalls in bursts
  always @(posedge clk_i) begin
    if (calm || !rst_ni) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((rx_valid && rx_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // called at a rising edge; returns at the edge where the transaction completes
  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 3) == 0) begin
      rx_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    @(negedge clk_i);
    while (!rx_ready) @(negedge clk_i);
    @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] rc, input logic [39:0] dig,
                            input logic [7:0] fc, input logic [39:0] flags,
                            input logic [7:0] cr);
    send_byte(rc);
    for (int i = 4; i >= 0; i--) send_byte(dig[i*8 +: 8]);
    send_byte(fc);
    for (int i = 4; i >= 0; i--) send_byte(flags[i*8 +: 8]);
    send_byte(cr);
    send_byte(ChLf);
  endtask

  function automatic logic [7:0] pick_function();
    case ($urandom_range(0, 10))
      0: return FcVolt;
      1: return FcCurA;
      2: return FcCurMa;
      3: return FcCurUa;
      4: return FcRes;
      5: return FcDiode;
      6: return FcFreq;
      7: return FcCap;
      8: return FcCond;
      9: return 8'h30 | 8'($urandom_range(0, 15));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [39:0] random_digits();
    logic [39:0] v;
    for (int i = 0; i < 5; i++)
      v[i*8 +: 8] = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                                : ChZero + 8'($urandom_range(0, 9));
    return v;
  endfunction

  function automatic logic [39:0] random_flags();
    logic [39:0] v;
    for (int i = 0; i < 5; i++)
      v[i*8 +: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'h30 | 8'($urandom_range(0, 15));
    return v;
  endfunction

  initial begin
    logic [7:0] rc;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every function, sign, odd digit strings, bad frames
    send_frame(8'h37, "99999", FcCap, 40'h3030303030, ChCr);
    send_frame(8'h37, "99999", FcCap, 40'h3434303030, ChCr);
    send_frame(8'h30, "00000", FcVolt, 40'h3030303030, ChCr);
    send_frame(8'h34, "12345", FcVolt, 40'h3f3f3f3f3f, ChCr);
    send_frame(8'h33, "54321", FcVolt, 40'h3430343434, ChCr);
    send_frame(8'h30, "77777", FcCurA, 40'h3130303030, ChCr);
    send_frame(8'h31, "1A234", FcCurMa, 40'h3030383030, ChCr);
    send_frame(8'h31, "A1234", FcCurUa, 40'h3030323030, ChCr);
    send_frame(8'h36, "98765", FcRes, 40'h3830303130, ChCr);
    send_frame(8'h39, "01234", FcDiode, 40'h3030303030, ChCr);
    send_frame(8'h37, "43210", FcFreq, 40'h3030303130, ChCr);
    send_frame(8'h32, "43210", FcFreq, 40'h3030303130, ChCr);
    send_frame(8'h7f, "11111", FcCond, 40'hffffffffff, ChCr);
    send_frame(8'h38, "11111", FcCap, 40'h3030303030, ChCr);
    send_frame(8'h30, "11111", 8'h00, 40'h3030303030, ChCr);
    send_frame(8'h00, "11111", FcVolt, 40'h3030303030, ChCr);
    send_frame(8'h30, "11111", FcVolt, 40'h3030303030, 8'h0c);
    send_byte(ChLf);
    send_byte(8'hff);

    while (bytes_sent < ByteTarget) begin
      if (bytes_sent > ByteTarget - 150) calm = 1;
      case ($urandom_range(0, 9))
        0: send_byte(8'($urandom_range(0, 255)));
        1: send_frame(8'($urandom_range(0, 255)), random_digits(), pick_function(),
                      random_flags(),
                      ($urandom_range(0, 1) != 0) ? ChCr : 8'($urandom_range(0, 255)));
        default: begin
          rc = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                           : ChZero + 8'($urandom_range(0, 9));
          send_frame(rc, random_digits(), pick_function(), random_flags(), ChCr);
        end
      endcase
    end
    rx_valid <= 1'b0;

    while (frames_pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && frames_pending == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
